/* src/hdlcd_pkg.sv */
// ----------------------------------------------------------------------------
// hdlcd_pkg
// Types and constants shared by the HDLC receive bit destuffer.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [3:0] STUFF_RUN = 4'd5;   // zero after this many ones is dropped
    localparam logic [3:0] FLAG_RUN  = 4'd6;   // zero after this many ones closes a frame
    localparam logic [3:0] ONES_MAX  = 4'd15;  // saturation, also idle line threshold
    localparam logic [3:0] FULL_BITS = 4'd8;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TERM = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FRAME_ERR = 2'd1,
        ST_ABORT     = 2'd2,
        ST_IDLE      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_FRAME = 3'b010,
        PH_ENDED = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       kind;
        t_status    frame_status;
        logic [3:0] valid_bits;
        logic       run_end;
    } t_result;

endpackage

/* src/hdlcd_step.sv */
// ----------------------------------------------------------------------------
// hdlcd_step
// Frame state and unrolled eight-bit destuffing; one byte per enabled cycle.
// Gives up to two results: a full byte first, then a terminal result.
// ----------------------------------------------------------------------------
module hdlcd_step
    import hdlcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_rx_byte,
    input  logic       i_first_byte,
    input  logic       i_final_byte,
    output logic [1:0] o_cnt,
    output t_result    o_slot0,
    output t_result    o_slot1
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_ones,  n_ones;
    logic [2:0] r_pos,   n_pos;
    logic [7:0] r_shift, n_shift;

    logic       ended;
    logic       keep;
    logic       bit_v;
    logic       full_v;
    logic [7:0] full_data;
    logic       term_v;
    t_result    term;

    always_comb begin
        n_phase   = r_phase;
        n_ones    = r_ones;
        n_pos     = r_pos;
        n_shift   = r_shift;
        ended     = 1'b0;
        keep      = 1'b0;
        bit_v     = 1'b0;
        full_v    = 1'b0;
        full_data = '0;
        term_v    = 1'b0;
        term      = '{data_byte: '0, kind: KIND_TERM, frame_status: ST_FRAME_ERR,
                      valid_bits: '0, run_end: 1'b1};

        if (i_first_byte) begin
            n_ones  = '0;
            n_pos   = 3'd7;
            n_shift = '0;
            if (i_rx_byte != FLAG_BYTE || i_final_byte) begin
                n_phase = PH_ENDED;
                term_v  = 1'b1;
            end else begin
                n_phase = PH_FRAME;
            end
        end else if (r_phase == PH_FRAME) begin
            for (int b = 7; b >= 0; b--) begin
                if (!ended) begin
                    bit_v = i_rx_byte[3'(b)];
                    keep  = 1'b1;
                    if (bit_v) begin
                        if (n_ones != ONES_MAX) begin
                            n_ones = n_ones + 4'd1;
                        end
                    end else if (n_ones >= FLAG_RUN) begin
                        // closing zero: six ones is a flag, more is abort or idle
                        term_v = 1'b1;
                        term.data_byte    = n_shift;
                        term.valid_bits   = {1'b0, 3'd7 - n_pos};
                        term.frame_status = (n_ones == FLAG_RUN) ? ST_OK :
                                            (n_ones == ONES_MAX) ? ST_IDLE : ST_ABORT;
                        ended = 1'b1;
                        keep  = 1'b0;
                    end else if (n_ones == STUFF_RUN) begin
                        n_ones = '0;
                        keep   = 1'b0;
                    end else begin
                        n_ones = '0;
                    end
                    if (keep) begin
                        n_shift[n_pos] = bit_v;
                        if (n_pos == 3'd0) begin
                            full_v    = 1'b1;
                            full_data = n_shift;
                            n_shift   = '0;
                            n_pos     = 3'd7;
                        end else begin
                            n_pos = n_pos - 3'd1;
                        end
                    end
                end
            end
            if (!ended && i_final_byte) begin
                term_v = 1'b1;
                term.data_byte  = n_shift;
                term.valid_bits = {1'b0, 3'd7 - n_pos};
            end
            if (term_v) begin
                n_phase = PH_ENDED;
                n_ones  = '0;
                n_pos   = 3'd7;
                n_shift = '0;
            end
        end
    end

    always_comb begin
        o_slot1 = term;
        if (full_v) begin
            o_slot0 = '{data_byte: full_data, kind: KIND_DATA, frame_status: ST_OK,
                        valid_bits: FULL_BITS, run_end: !term_v};
            o_cnt   = term_v ? 2'd2 : 2'd1;
        end else begin
            o_slot0 = term;
            o_cnt   = term_v ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_ones  <= '0;
            r_pos   <= 3'd7;
            r_shift <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_ones  <= n_ones;
            r_pos   <= n_pos;
            r_shift <= n_shift;
        end
    end

endmodule

/* src/hdlcd_outq.sv */
// ----------------------------------------------------------------------------
// hdlcd_outq
// Four-entry result queue: up to two results in a cycle, one out per pop.
// ----------------------------------------------------------------------------
module hdlcd_outq
    import hdlcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_slot0,
    input  t_result    i_slot1,
    output logic       o_room,
    input  logic       i_pop,
    output logic       o_not_empty,
    output t_result    o_head
);

    t_result    r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign o_not_empty = (r_cnt != 3'd0);
    assign pop         = i_pop && o_not_empty;
    // room for two more results after this cycle's pop
    assign o_room      = (r_cnt <= 3'd2) || (r_cnt == 3'd3 && pop);
    assign o_head      = r_mem[r_rd];

    assign n_wr  = r_wr + i_push_cnt;
    assign n_rd  = r_rd + {1'b0, pop};
    assign n_cnt = r_cnt + {1'b0, i_push_cnt} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_slot0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* src/hdlc_bit_destuffer.sv */
// ----------------------------------------------------------------------------
// hdlc_bit_destuffer
// HDLC receive bit destuffer: checks the opening flag, drops stuffed zeros,
// repacks bytes msb first and reports how each frame ends.
// ----------------------------------------------------------------------------
//   channel  valid         stall         payload
//   in       i_in_valid    o_in_stall    i_rx_byte, i_first_byte, i_final_byte
//   out      o_out_valid   i_out_stall   o_data_byte, o_kind, o_frame_status,
//                                        o_valid_bits, o_run_end
//
// A byte is registered on accept and destuffed once the result queue has
// room for two results; its results are registered into that queue. One byte
// per cycle while the queue keeps that room; a byte giving two results is
// drained one result at a time by the single-read result queue (four entries).
// Reset is synchronous; the queue is emptied and the frame state returns to
// waiting for a first byte. o_in_stall rises only when the queue lacks room
// for two results.
// ----------------------------------------------------------------------------
module hdlc_bit_destuffer
    import hdlcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_first_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_byte,
    output logic       o_kind,
    output logic [1:0] o_frame_status,
    output logic [3:0] o_valid_bits,
    output logic       o_run_end
);

    logic       r_in_v, n_in_v;
    logic [7:0] r_rx;
    logic       r_first;
    logic       r_final;

    logic       room;
    logic       proc;
    logic       in_acc;
    logic [1:0] step_cnt;
    logic [1:0] push_cnt;
    t_result    slot0, slot1, head;

    assign proc       = r_in_v && room;
    assign o_in_stall = r_in_v && !room;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign n_in_v     = in_acc || (r_in_v && !proc);
    assign push_cnt   = proc ? step_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= n_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rx    <= i_rx_byte;
            r_first <= i_first_byte;
            r_final <= i_final_byte;
        end
    end

    hdlcd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (proc),
        .i_rx_byte    (r_rx),
        .i_first_byte (r_first),
        .i_final_byte (r_final),
        .o_cnt        (step_cnt),
        .o_slot0      (slot0),
        .o_slot1      (slot1)
    );

    hdlcd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_slot0     (slot0),
        .i_slot1     (slot1),
        .o_room      (room),
        .i_pop       (!i_out_stall),
        .o_not_empty (o_out_valid),
        .o_head      (head)
    );

    assign o_data_byte    = head.data_byte;
    assign o_kind         = head.kind;
    assign o_frame_status = head.frame_status;
    assign o_valid_bits   = head.valid_bits;
    assign o_run_end      = head.run_end;

endmodule

/* src/hdlcd_checker.sv */
// ----------------------------------------------------------------------------
// hdlcd_checker
// Port-level checks on the destuffer's result stream.
// ----------------------------------------------------------------------------
module hdlcd_checker
    import hdlcd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_data_byte,
    input logic       o_kind,
    input logic [1:0] o_frame_status,
    input logic [3:0] o_valid_bits,
    input logic       o_run_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_kind) && $stable(o_frame_status)
            && $stable(o_valid_bits) && $stable(o_run_end))
        else $error("result changed while stalled");

    a_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DATA |->
            o_valid_bits == FULL_BITS && o_frame_status == ST_OK)
        else $error("full byte with bad count or status");

    a_term_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_TERM |->
            o_run_end && o_valid_bits < FULL_BITS
            && (o_data_byte & (8'hFF >> o_valid_bits)) == 8'h00)
        else $error("terminal result malformed");

    // a full byte not closing its run is followed at once by the terminal result
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DATA && !o_run_end && !i_out_stall |=>
            o_out_valid && o_kind == KIND_TERM)
        else $error("terminal result missing after full byte");

endmodule

bind hdlc_bit_destuffer hdlcd_checker u_hdlcd_checker (.*);
